>>> rtl/core/smlb_pkg.sv
package smlb_pkg;

  // default build values
  localparam int unsigned TicksPerSecondDef = 1000;
  localparam int unsigned MaxPinsDef        = 8;

  // divisor is twice the frequency, at most 2 * 99
  localparam int unsigned DivW = 8;

  // characters of interest
  localparam logic [7:0] ChCr   = 8'd13;
  localparam logic [7:0] ChF    = 8'd70;
  localparam logic [7:0] ChP    = 8'd80;
  localparam logic [7:0] ChZero = 8'd48;
  localparam logic [7:0] ChNine = 8'd57;

  typedef enum logic [1:0] {
    MODE_MENU = 2'd0,
    MODE_FREQ = 2'd1,
    MODE_PINS = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_DIV  = 2'd2,
    ST_OUT  = 2'd3
  } state_e;

endpackage

>>> rtl/core/serial_menu_led_blinker.sv
// flow: one transfer in, then the EVAL state and the OUT state when no reload is due,
// or EVAL, the DIV steps and OUT when the blink counter reloads; OUT holds until the result is taken
// a new input is taken only in IDLE, once the last result has been taken;
// the reload value comes from a restoring divider that retires one quotient bit a cycle
// reset: asynchronous, active low; menu mode, frequency 1, one pin, counter zero, leds off
module serial_menu_led_blinker
  import smlb_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = TicksPerSecondDef,
  parameter int unsigned MAX_PINS         = MaxPinsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] led_pins_o,
  output logic [6:0] blink_freq_o,
  output logic [3:0] pin_count_o,
  output logic [1:0] prompt_mode_o
);

  localparam int unsigned QuoW = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned CntW = $clog2(TICKS_PER_SECOND / 2 + 1);
  localparam int unsigned StepW = $clog2(QuoW);
  localparam logic [QuoW-1:0] Dividend = QuoW'(TICKS_PER_SECOND);
  localparam logic [StepW-1:0] LastStep = StepW'(QuoW - 1);
  localparam logic [3:0] MaxPinsC = 4'(MAX_PINS);

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  logic            started_q, started_d;
  logic [7:0]      first_char_q, first_char_d;
  logic [6:0]      dig_val_q, dig_val_d;
  logic [3:0]      dig_first_q, dig_first_d;
  logic [1:0]      dig_seen_q, dig_seen_d;
  logic            dig_stop_q, dig_stop_d;
  logic [6:0]      freq_q, freq_d;
  logic [3:0]      pins_q, pins_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      led_q, led_d;

  logic [DivW-1:0]  rem_q, rem_d;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [StepW-1:0] step_q, step_d;

  logic            in_xfer;
  logic            out_xfer;
  logic [7:0]      first_eff;
  logic            is_digit;
  logic [3:0]      digit;
  logic [6:0]      freq_eff;
  logic [DivW-1:0] divisor;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic [8:0]      mask_wide;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // byte decode
  assign first_eff = started_q ? first_char_q : rx_byte_i;
  assign is_digit  = (rx_byte_i >= ChZero) && (rx_byte_i <= ChNine);
  assign digit     = 4'(rx_byte_i - ChZero);

  // divider step and led mask
  assign freq_eff  = (freq_q == 7'd0) ? 7'd1 : freq_q;
  assign divisor   = {freq_eff, 1'b0};
  assign trial     = {rem_q, quo_q[QuoW-1]};
  assign diff      = trial - {1'b0, divisor};
  assign mask_wide = (9'd1 << pins_q) - 9'd1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = (count_q == '0) ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (step_q == '0) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_xfer) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o  = 1'b1;
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    mode_d       = mode_q;
    started_d    = started_q;
    first_char_d = first_char_q;
    dig_val_d    = dig_val_q;
    dig_first_d  = dig_first_q;
    dig_seen_d   = dig_seen_q;
    dig_stop_d   = dig_stop_q;
    freq_d       = freq_q;
    pins_d       = pins_q;
    count_d      = count_q;
    led_d        = led_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    step_d       = step_q;

    if (state_q == ST_IDLE && in_xfer) begin
      if (cmd_i) begin
        // tick, counter stops at zero
        if (count_q != '0) count_d = count_q - CntW'(1);
      end else if (rx_byte_i == ChCr) begin
        // end of line
        unique case (mode_q)
          MODE_MENU: begin
            if (first_eff == ChF) mode_d = MODE_FREQ;
            else if (first_eff == ChP) mode_d = MODE_PINS;
          end
          MODE_FREQ: begin
            if (dig_seen_q != 2'd0 && dig_val_q != 7'd0) begin
              freq_d = dig_val_q;
              mode_d = MODE_MENU;
            end
          end
          default: begin
            if (dig_seen_q != 2'd0 && dig_first_q >= 4'd1 && dig_first_q <= MaxPinsC) begin
              pins_d = dig_first_q;
              mode_d = MODE_MENU;
            end
          end
        endcase
        started_d    = 1'b0;
        first_char_d = 8'd0;
        dig_val_d    = 7'd0;
        dig_first_d  = 4'd0;
        dig_seen_d   = 2'd0;
        dig_stop_d   = 1'b0;
      end else begin
        // ordinary byte of a line
        if (!started_q) begin
          first_char_d = rx_byte_i;
          started_d    = 1'b1;
        end
        if (!dig_stop_q) begin
          if (is_digit) begin
            if (dig_seen_q != 2'd2) begin
              dig_val_d  = 7'({dig_val_q, 3'b000}) + 7'({dig_val_q, 1'b0}) + 7'(digit);
              dig_seen_d = dig_seen_q + 2'd1;
              if (dig_seen_q == 2'd0) dig_first_d = digit;
            end
          end else begin
            dig_stop_d = 1'b1;
          end
        end
      end
    end

    // start the reload division
    if (state_q == ST_EVAL) begin
      rem_d  = '0;
      quo_d  = Dividend;
      step_d = LastStep;
    end

    // one quotient bit per cycle, reload and toggle at the end
    if (state_q == ST_DIV) begin
      if (!diff[DivW]) begin
        rem_d = diff[DivW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b0};
      end
      step_d = step_q - StepW'(1);
      if (step_q == '0) begin
        count_d = !diff[DivW] ? CntW'({quo_q[QuoW-2:0], 1'b1})
                              : CntW'({quo_q[QuoW-2:0], 1'b0});
        led_d   = (led_q == 8'd0) ? mask_wide[7:0] : 8'd0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= MODE_MENU;
      started_q    <= 1'b0;
      first_char_q <= 8'd0;
      dig_val_q    <= 7'd0;
      dig_first_q  <= 4'd0;
      dig_seen_q   <= 2'd0;
      dig_stop_q   <= 1'b0;
      freq_q       <= 7'd1;
      pins_q       <= 4'd1;
      count_q      <= '0;
      led_q        <= 8'd0;
      step_q       <= '0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      started_q    <= started_d;
      first_char_q <= first_char_d;
      dig_val_q    <= dig_val_d;
      dig_first_q  <= dig_first_d;
      dig_seen_q   <= dig_seen_d;
      dig_stop_q   <= dig_stop_d;
      freq_q       <= freq_d;
      pins_q       <= pins_d;
      count_q      <= count_d;
      led_q        <= led_d;
      step_q       <= step_d;
    end
  end

  // divider working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign led_pins_o    = led_q;
  assign blink_freq_o  = freq_q;
  assign pin_count_o   = pins_q;
  assign prompt_mode_o = mode_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import smlb_pkg::*;

  localparam int unsigned TicksPerSec = TicksPerSecondDef;
  localparam int unsigned MaxPins     = MaxPinsDef;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned HoldCycles  = 250;

  // one observed blinker status
  typedef struct packed {
    logic [7:0] led;
    logic [6:0] freq;
    logic [3:0] pins;
    logic [1:0] mode;
  } blink_status_t;

  // menu parser and blink counter mirror, plus the queue of pending statuses
  class blink_scoreboard;
    mode_e         mode;
    logic [7:0]    first_char;
    logic [1:0]    line_pos;
    logic [6:0]    digit_val;
    logic [1:0]    digit_cnt;
    bit            digits_done;
    logic [6:0]    freq;
    logic [3:0]    pins;
    logic [8:0]    countdown;
    logic [7:0]    led;
    blink_status_t status_q[$];
    int unsigned   n_mismatch;
    int unsigned   n_results;
    int unsigned   n_toggles;
    int unsigned   n_freq_sets;
    int unsigned   n_pin_sets;

    function new();
      mode        = MODE_MENU;
      clear_line();
      freq        = 7'd1;
      pins        = 4'd1;
      countdown   = '0;
      led         = '0;
      n_mismatch  = 0;
      n_results   = 0;
      n_toggles   = 0;
      n_freq_sets = 0;
      n_pin_sets  = 0;
    endfunction

    function void clear_line();
      first_char  = '0;
      line_pos    = '0;
      digit_val   = '0;
      digit_cnt   = '0;
      digits_done = 1'b0;
    endfunction

    // carriage return: act on the finished line
    function void close_line();
      int unsigned lead;
      case (mode)
        MODE_MENU: begin
          if (first_char == ChF) mode = MODE_FREQ;
          else if (first_char == ChP) mode = MODE_PINS;
        end
        MODE_FREQ: begin
          if (digit_cnt != 0 && digit_val != 0) begin
            freq = digit_val;
            mode = MODE_MENU;
            n_freq_sets++;
          end
        end
        default: begin
          // pin prompt looks at the first digit only
          if (digit_cnt != 0) begin
            lead = (digit_cnt >= 2) ? int'(digit_val) / 10 : int'(digit_val);
            if (lead >= 1 && lead <= MaxPins) begin
              pins = 4'(lead);
              mode = MODE_MENU;
              n_pin_sets++;
            end
          end
        end
      endcase
      clear_line();
    endfunction

    // transfer accepted on the input side
    function void note_input(bit is_tick, logic [7:0] ch);
      int unsigned div;
      int unsigned n;
      blink_status_t st;
      if (is_tick) begin
        if (countdown != 0) countdown = countdown - 9'd1;
      end else begin
        if (line_pos == 0) first_char = ch;
        if (line_pos < 3) line_pos = line_pos + 2'd1;
        if (ch == ChCr) begin
          close_line();
        end else if (!digits_done) begin
          // leading digits, at most two kept
          if (ch >= ChZero && ch <= ChNine) begin
            if (digit_cnt < 2) begin
              digit_val = 7'(int'(digit_val) * 10 + int'(ch - ChZero));
              digit_cnt = digit_cnt + 2'd1;
            end
          end else begin
            digits_done = 1'b1;
          end
        end
      end
      // reload and toggle whenever the counter sits at zero
      if (countdown == 0) begin
        div       = (freq == 0) ? 2 : 2 * int'(freq);
        countdown = 9'(TicksPerSec / div);
        if (led == 0) begin
          n   = (pins > 8) ? 8 : int'(pins);
          led = 8'((1 << n) - 1);
        end else begin
          led = '0;
        end
        n_toggles++;
      end
      st.led  = led;
      st.freq = freq;
      st.pins = pins;
      st.mode = 2'(mode);
      status_q.push_back(st);
    endfunction

    // transfer accepted on the output side
    function void check_result(blink_status_t got);
      blink_status_t want;
      n_results++;
      if (status_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= ReportMax)
          $display("%0t: unexpected result led %h freq %0d pins %0d mode %0d", $time,
                   got.led, got.freq, got.pins, got.mode);
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= ReportMax)
            $display("%0t: mismatch led %h/%h freq %0d/%0d pins %0d/%0d mode %0d/%0d (exp/act)",
                     $time, want.led, got.led, want.freq, got.freq, want.pins, got.pins,
                     want.mode, got.mode);
        end
      end
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       cmd_i;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] led_pins_o;
  logic [6:0] blink_freq_o;
  logic [3:0] pin_count_o;
  logic [1:0] prompt_mode_o;

  blink_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  bit              hold_request;
  int unsigned     n_items;
  int unsigned     cycle_cnt;

  serial_menu_led_blinker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .led_pins_o    (led_pins_o),
    .blink_freq_o  (blink_freq_o),
    .pin_count_o   (pin_count_o),
    .prompt_mode_o (prompt_mode_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // cycle counter and timeout
  initial cycle_cnt = 0;
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, sb.pending());
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    blink_status_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.led  = led_pins_o;
      got.freq = blink_freq_o;
      got.pins = pin_count_o;
      got.mode = prompt_mode_o;
      sb.check_result(got);
    end
  end

  // one input transfer; called and returns just after a falling edge
  task automatic send_item(bit is_tick, logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= is_tick;
    rx_byte_i  <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(is_tick, ch);
    n_items++;
    @(negedge clk_i);
  endtask

  // tick carries a junk byte, which the block ignores
  task automatic send_tick();
    send_item(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic send_line(string txt);
    for (int i = 0; i < txt.len(); i++) send_item(1'b0, txt[i]);
    send_item(1'b0, ChCr);
  endtask

  // stop offering and let every pending result come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(2) == 0) return ChZero + 8'($urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  // one random command sequence, mostly well formed
  task automatic run_session();
    int unsigned pick;
    string       txt;
    pick = $urandom_range(99);
    if (pick < 45) begin
      repeat ($urandom_range(1, 60)) send_tick();
    end else if (pick < 60) begin
      // frequency entry
      send_line("F");
      case ($urandom_range(9))
        0:       txt = $sformatf("%0d", $urandom_range(1, 9));
        1:       txt = ($urandom_range(1) != 0) ? "0" : "00";
        2:       txt = $sformatf("%0d", $urandom_range(100, 999));
        3:       txt = $sformatf("%0d%c", $urandom_range(10, 99), rand_char());
        default: txt = $sformatf("%0d", $urandom_range(10, 99));
      endcase
      send_line(txt);
    end else if (pick < 72) begin
      // pin-count entry
      send_line("P");
      txt = $sformatf("%0d", $urandom_range(0, 9));
      if ($urandom_range(3) == 0) txt = {txt, string'(rand_char())};
      send_line(txt);
    end else if (pick < 88) begin
      // free line with random content
      case ($urandom_range(3))
        0:       send_item(1'b0, ChF);
        1:       send_item(1'b0, ChP);
        default: send_item(1'b0, rand_char());
      endcase
      repeat ($urandom_range(0, 5)) send_item(1'b0, rand_char());
      send_item(1'b0, ChCr);
    end else begin
      send_item(1'b0, 8'($urandom_range(255)));
    end
  endtask

  // main sequence
  initial begin
    int unsigned phase_start;
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = 1'b0;
    rx_byte_i     = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b0;
    n_items       = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: first step after reset, empty lines, rejected and accepted values
    send_tick();
    send_item(1'b0, ChCr);
    send_line("F");
    send_item(1'b0, ChCr);
    send_line("0");
    send_line("995");
    send_line("P");
    send_line("9");
    send_line("0");
    send_line("x8");
    send_line("85");
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h00);
    send_item(1'b0, ChCr);
    repeat (3) send_tick();
    wait_drained();

    // random: three idling profiles, long receiver hold-off in the last one
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 15; recv_idle_pct = 56; end
        1:       begin send_idle_pct = 56; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  hold_request = 1'b1; end
      endcase
      phase_start = n_items;
      while (n_items - phase_start < 233 || sb.n_toggles < 16 * (phase + 1)) run_session();
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    $display("covered %0d transfers in, %0d results, %0d led toggles", n_items,
             sb.n_results, sb.n_toggles);
    $display("accepted %0d frequency and %0d pin-count updates, %0d mismatches",
             sb.n_freq_sets, sb.n_pin_sets, sb.n_mismatch);
    if (sb.n_mismatch == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/smlb_pkg.sv
rtl/core/serial_menu_led_blinker.sv
tb/tb.sv
